FILE: rtl/mstb_pkg.sv
// ----------------------------------------------------------------------------
// mstb_pkg
// Shared types and codes of the multi-slot token bucket: command and
// response items, the classified operation that crosses the internal queue,
// command and status codes, and default sizes.
// ----------------------------------------------------------------------------
package mstb_pkg;

	// Default sizes
	localparam int SLOTS_DEF      = 16;
	localparam int TOKEN_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	// Command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_OPEN  = 3'd1;
	localparam logic [2:0] CMD_FETCH = 3'd2;
	localparam logic [2:0] CMD_GIVE  = 3'd3;
	localparam logic [2:0] CMD_CLOSE = 3'd4;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_BLOCK    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOT_OPEN = 3'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  slot;
		logic [15:0] amount;
		logic [15:0] fill_rate;
		logic [15:0] burst_limit;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_given;
		logic [15:0] count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_OPEN,
		OP_FETCH,
		OP_GIVE,
		OP_CLOSE
	} op_kind_t;

	// Classified command as handed from front to back
	typedef struct packed {
		op_kind_t    kind;
		logic        slot_ok;
		logic        amount_zero;
		logic [3:0]  slot;
		logic [15:0] amount;
		logic [15:0] fill_rate;
		logic [15:0] burst_limit;
	} op_t;

endpackage

FILE: rtl/mstb_front.sv
// ----------------------------------------------------------------------------
// mstb_front
// Command front end: decodes the command code, checks the slot against the
// table size and flags a zero amount, then hands the item to the queue.
// ----------------------------------------------------------------------------
module mstb_front import mstb_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic op_valid,
	input  logic op_stall,
	output op_t  op
);

	op_kind_t kind;

	// Decode command code
	always_comb begin
		unique case (cmd.command)
			CMD_TICK:  kind = OP_TICK;
			CMD_OPEN:  kind = OP_OPEN;
			CMD_FETCH: kind = OP_FETCH;
			CMD_GIVE:  kind = OP_GIVE;
			CMD_CLOSE: kind = OP_CLOSE;
			default:   kind = OP_NOP;
		endcase
	end

	// Classify and forward
	always_comb begin
		op.kind        = kind;
		op.slot_ok     = int'(cmd.slot) < SLOTS;
		op.amount_zero = TOKEN_BITS'(cmd.amount) == '0;
		op.slot        = cmd.slot;
		op.amount      = cmd.amount;
		op.fill_rate   = cmd.fill_rate;
		op.burst_limit = cmd.burst_limit;
	end

	assign op_valid  = cmd_valid;
	assign cmd_stall = op_stall;

endmodule

FILE: rtl/mstb_queue.sv
// ----------------------------------------------------------------------------
// mstb_queue
// Short queue of classified operations between front and back, so the
// front keeps taking items, until the queue is full, while the back walks the table.
// ----------------------------------------------------------------------------
module mstb_queue import mstb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_stall,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_stall,
	output op_t  pop_op
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	logic             pop;

	assign push_stall = fill_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

FILE: rtl/mstb_back.sv
// ----------------------------------------------------------------------------
// mstb_back
// Command execution: holds the slot tables, walks them for tick and open,
// does the read-modify-write for fetch and give back, and holds the
// response in an output register.
// ----------------------------------------------------------------------------
module mstb_back import mstb_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_TICK
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SLOT_W-1:0]      tick_idx_s1;
	logic [SLOTS-1:0]       open_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic [TOKEN_BITS-1:0]  rate_mem [SLOTS];
	logic [TOKEN_BITS-1:0]  ceil_mem [SLOTS];
	logic [TOKEN_BITS-1:0]  tok_mem  [SLOTS];
	logic [TOKEN_BITS-1:0]  rd_rate_q;
	logic [TOKEN_BITS-1:0]  rd_ceil_q;
	logic [TOKEN_BITS-1:0]  rd_tok_q;

	logic                   start;
	logic [SLOT_W-1:0]      in_idx;
	logic [SLOT_W-1:0]      cur_idx;
	logic [SLOT_W-1:0]      scan_idx;
	logic                   usable;
	logic                   cnt_done;
	logic                   cnt_last;
	logic                   rd_en;
	logic [SLOT_W-1:0]      rd_addr;
	logic                   tok_we;
	logic                   cfg_we;
	logic [SLOT_W-1:0]      wr_addr;
	logic [TOKEN_BITS-1:0]  tok_wdata;
	logic [TOKEN_BITS-1:0]  amt_m;
	logic [TOKEN_BITS-1:0]  sat_b;
	logic [TOKEN_BITS:0]    sat_sum;
	logic [TOKEN_BITS-1:0]  sat_res;
	logic [TOKEN_BITS-1:0]  grant;

	assign op_stall  = !(state_q == S_IDLE && !rsp_valid_q);
	assign start     = op_valid && !op_stall;
	assign in_idx    = SLOT_W'(op.slot);
	assign cur_idx   = SLOT_W'(op_q.slot);
	assign scan_idx  = cnt_q[SLOT_W-1:0];
	assign usable    = op.slot_ok && open_q[in_idx];
	assign cnt_done  = cnt_q == CNT_W'(SLOTS);
	assign cnt_last  = cnt_q == CNT_W'(SLOTS - 1);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Saturating add shared by tick and give back
	assign amt_m   = TOKEN_BITS'(op_q.amount);
	assign sat_b   = (state_q == S_TICK) ? rd_rate_q : amt_m;
	assign sat_sum = {1'b0, rd_tok_q} + {1'b0, sat_b};
	assign sat_res = (sat_sum > {1'b0, rd_ceil_q}) ? rd_ceil_q : sat_sum[TOKEN_BITS-1:0];
	assign grant   = (rd_tok_q < amt_m) ? rd_tok_q : amt_m;

	// Select table read address
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = in_idx;
		if (state_q == S_IDLE) begin
			if (start && op.kind == OP_TICK) begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end else if (start && usable && (op.kind == OP_FETCH || op.kind == OP_GIVE)) begin
				rd_en   = 1'b1;
				rd_addr = in_idx;
			end
		end else if (state_q == S_TICK && !cnt_done) begin
			rd_en   = 1'b1;
			rd_addr = scan_idx;
		end
	end

	// Select table write
	always_comb begin
		tok_we    = 1'b0;
		cfg_we    = 1'b0;
		wr_addr   = cur_idx;
		tok_wdata = sat_res;
		case (state_q)
			S_TICK: begin
				tok_we  = open_q[tick_idx_s1];
				wr_addr = tick_idx_s1;
			end
			S_EXEC: begin
				if (op_q.kind == OP_FETCH) begin
					tok_we    = rd_tok_q != '0;
					tok_wdata = rd_tok_q - grant;
				end else begin
					tok_we = 1'b1;
				end
			end
			S_SCAN: begin
				tok_we    = !open_q[scan_idx];
				cfg_we    = !open_q[scan_idx];
				wr_addr   = scan_idx;
				tok_wdata = '0;
			end
			default: begin
				tok_we = 1'b0;
			end
		endcase
	end

	// Write tables
	always_ff @(posedge clk) begin
		if (tok_we) begin
			tok_mem[wr_addr] <= tok_wdata;
		end
		if (cfg_we) begin
			rate_mem[wr_addr] <= TOKEN_BITS'(op_q.fill_rate);
			ceil_mem[wr_addr] <= TOKEN_BITS'(op_q.burst_limit);
		end
	end

	// Read tables
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_rate_q <= rate_mem[rd_addr];
			rd_ceil_q <= ceil_mem[rd_addr];
			rd_tok_q  <= tok_mem[rd_addr];
		end
	end

	// Sequence commands and hold the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			open_q      <= '0;
			cnt_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= op;
						unique case (op.kind) inside
							OP_TICK: begin
								cnt_q       <= CNT_W'(1);
								tick_idx_s1 <= '0;
								state_q     <= S_TICK;
							end
							OP_OPEN: begin
								cnt_q   <= '0;
								state_q <= S_SCAN;
							end
							OP_FETCH, OP_GIVE: begin
								if (!usable) begin
									rsp_valid_q <= 1'b1;
									rsp_q       <= '{ST_NOT_OPEN, 4'd0, 16'd0};
								end else if (op.kind == OP_FETCH && op.amount_zero) begin
									rsp_valid_q <= 1'b1;
									rsp_q       <= '{ST_INVALID, 4'd0, 16'd0};
								end else begin
									state_q <= S_EXEC;
								end
							end
							OP_CLOSE: begin
								rsp_valid_q <= 1'b1;
								if (!usable) begin
									rsp_q <= '{ST_NOT_OPEN, 4'd0, 16'd0};
								end else begin
									open_q[in_idx] <= 1'b0;
									rsp_q          <= '{ST_OK, 4'd0, 16'd0};
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_q       <= '{ST_OK, 4'd0, 16'd0};
							end
						endcase
					end
				end
				S_EXEC: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
					if (op_q.kind == OP_FETCH) begin
						if (rd_tok_q == '0) begin
							rsp_q <= '{ST_BLOCK, 4'd0, 16'd0};
						end else begin
							rsp_q <= '{ST_OK, 4'd0, 16'(grant)};
						end
					end else begin
						rsp_q <= '{ST_OK, 4'd0, 16'(amt_m)};
					end
				end
				S_SCAN: begin
					if (!open_q[scan_idx]) begin
						open_q[scan_idx] <= 1'b1;
						rsp_valid_q      <= 1'b1;
						rsp_q            <= '{ST_OK, 4'(scan_idx), 16'd0};
						state_q          <= S_IDLE;
					end else if (cnt_last) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{ST_FULL, 4'd0, 16'd0};
						state_q     <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TICK: begin
					if (!cnt_done) begin
						tick_idx_s1 <= scan_idx;
						cnt_q       <= cnt_q + 1'b1;
					end else begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{ST_OK, 4'd0, 16'd0};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/multi_slot_token_bucket.sv
// Close, unknown codes and rejected commands answer straight from the back
// end's response register; fetch and give back read the table, then update.
// Open walks the slot table up to the first closed slot and tick walks all
// of it, one entry per cycle. The queue registers each command on its way
// to the back end, which takes its next item in the cycle after its response is
// taken. Reset clears all slots to closed; rates, ceilings and tokens load on open.
// ----------------------------------------------------------------------------
// multi_slot_token_bucket
// Table of token buckets driven by one command per item: open, tick, fetch,
// give back and close, each answered by one response item.
// ----------------------------------------------------------------------------
module multi_slot_token_bucket import mstb_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic fr_valid;
	logic fr_stall;
	op_t  fr_op;
	logic bk_valid;
	logic bk_stall;
	op_t  bk_op;

	// Decode and classify
	mstb_front #(
		.SLOTS      (SLOTS),
		.TOKEN_BITS (TOKEN_BITS)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.op_valid  (fr_valid),
		.op_stall  (fr_stall),
		.op        (fr_op)
	);

	// Decouple front and back
	mstb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_stall (fr_stall),
		.push_op    (fr_op),
		.pop_valid  (bk_valid),
		.pop_stall  (bk_stall),
		.pop_op     (bk_op)
	);

	// Execute against the slot tables
	mstb_back #(
		.SLOTS      (SLOTS),
		.TOKEN_BITS (TOKEN_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (bk_valid),
		.op_stall  (bk_stall),
		.op        (bk_op),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/mstb_checker.sv
// ----------------------------------------------------------------------------
// mstb_checker
// Port-level checks of the token bucket: response hold under stall and
// consistency of the response fields with the status code.
// ----------------------------------------------------------------------------
module mstb_checker import mstb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Emit only defined status codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_INVALID ||
			rsp.status == ST_BLOCK || rsp.status == ST_FULL ||
			rsp.status == ST_NOT_OPEN)
		else $error("undefined status code");

	// Zero the data fields of a rejected command
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.count == 16'd0 && rsp.slot_given == 4'd0)
		else $error("rejected command carries data");

	// Report a slot only for a successful open, which grants no tokens
	a_given_open: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.slot_given != 4'd0 |-> rsp.status == ST_OK && rsp.count == 16'd0)
		else $error("slot number on a non-open response");

endmodule

bind multi_slot_token_bucket mstb_checker u_mstb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
